// File: rtl/fdss_pkg.sv
`default_nettype none
package fdss_pkg;

  localparam int DIGITS         = 4;
  localparam int FRAC_UNITS     = 4;
  localparam int VALUE_W        = 32;
  localparam int DP_W           = 3;
  localparam int SEG_W          = 8;
  localparam int STAGES         = 4;
  localparam int BITS_PER_STAGE = VALUE_W / STAGES;
  localparam int BCD_DIGITS     = FRAC_UNITS + DIGITS;
  localparam int BCD_W          = 4 * BCD_DIGITS;
  localparam int BCD_IDX_W      = $clog2(BCD_DIGITS);
  localparam int CNT_W          = $clog2(DIGITS + 1);
  localparam int IN_DATA_W      = ((VALUE_W + DP_W + 7) / 8) * 8;
  localparam int OUT_DATA_W     = 2 * SEG_W;

  localparam logic [SEG_W-1:0] BLANK   = 8'hFF;
  localparam logic [SEG_W-1:0] DP_MASK = 8'h7F;

  typedef struct packed {
    logic [VALUE_W-1:0] bin;
    logic [BCD_W-1:0]   bcd;
    logic [DP_W-1:0]    dp;
  } fdss_item_t;

  function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] d);
    logic [SEG_W-1:0] c;
    unique case (d)
      4'd0:    c = 8'hC0;
      4'd1:    c = 8'hF9;
      4'd2:    c = 8'hA4;
      4'd3:    c = 8'hB0;
      4'd4:    c = 8'h99;
      4'd5:    c = 8'h92;
      4'd6:    c = 8'h82;
      4'd7:    c = 8'hF8;
      4'd8:    c = 8'h80;
      4'd9:    c = 8'h90;
      default: c = BLANK;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// File: rtl/four_digit_seven_segment_frames.sv
// An input passes through the dabble stage registers and the output hold register
// before its first frame is shown. Each input yields DIGITS + 1 frames, or one frame
// if rejected; the single frame sequencer takes a new input as its last frame goes out.
// The 4-stage binary-to-BCD pipeline accepts an input in every cycle it can advance.
// Reset: asynchronous, active low; clears all valid bits and the frame counter.
`default_nettype none
module four_digit_seven_segment_frames
  import fdss_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // value[31:0], frac_digits[34:32]
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,  // segments[7:0], digit_select[15:8]
  output logic                       m_axis_tlast,
  output logic                       m_axis_tuser   // rejected
);

  logic       st_vld  [STAGES+1];
  fdss_item_t st_item [STAGES+1];
  logic       adv;

  logic             hold_vld_q, hold_vld_d;
  logic [BCD_W-1:0] hold_bcd_q;
  logic [DP_W-1:0]  hold_dp_q;
  logic             hold_rej_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic             frame_last;
  logic [CNT_W-1:0] dig_i;
  logic [7:0]       pos_full;
  logic [BCD_IDX_W-1:0] pos;
  logic [3:0]       digit;
  logic [SEG_W-1:0] seg, sel;

  assign st_vld[0]      = s_axis_tvalid;
  assign st_item[0].bin = s_axis_tdata[VALUE_W-1:0];
  assign st_item[0].bcd = '0;
  assign st_item[0].dp  = s_axis_tdata[VALUE_W +: DP_W];

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    fdss_dabble_stage u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .vld_i  (st_vld[g]),
      .item_i (st_item[g]),
      .vld_o  (st_vld[g+1]),
      .item_o (st_item[g+1])
    );
  end

  assign frame_last    = hold_rej_q || (cnt_q == CNT_W'(DIGITS));
  assign adv           = !hold_vld_q || (m_axis_tready && frame_last);
  assign s_axis_tready = adv;

  always_comb begin
    hold_vld_d = hold_vld_q;
    cnt_d      = cnt_q;
    if (adv) begin
      hold_vld_d = st_vld[STAGES];
      cnt_d      = '0;
    end else if (m_axis_tready) begin
      cnt_d = cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_vld_q <= 1'b0;
      cnt_q      <= '0;
    end else begin
      hold_vld_q <= hold_vld_d;
      cnt_q      <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hold_bcd_q <= st_item[STAGES].bcd;
      hold_dp_q  <= st_item[STAGES].dp;
      hold_rej_q <= (st_item[STAGES].dp > DP_W'(FRAC_UNITS));
    end
  end

  always_comb begin
    dig_i    = cnt_q - CNT_W'(1);
    pos_full = 8'(FRAC_UNITS) + 8'(dig_i) - 8'(hold_dp_q);
    pos      = pos_full[BCD_IDX_W-1:0];
    digit    = hold_bcd_q[pos*4 +: 4];
    if (cnt_q == '0) begin
      seg = BLANK;
      sel = BLANK;
    end else begin
      seg = seg_code(digit);
      if (8'(dig_i) == 8'(hold_dp_q)) begin
        seg = seg & DP_MASK;
      end
      sel = SEG_W'(1) << dig_i;
    end
  end

  assign m_axis_tvalid = hold_vld_q;
  assign m_axis_tdata  = {sel, seg};
  assign m_axis_tlast  = frame_last;
  assign m_axis_tuser  = hold_rej_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DIGITS))
    else $error("frame counter out of range");

  a_rej_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_vld_q && hold_rej_q |-> cnt_q == '0)
    else $error("rejected input advanced past the blanking frame");

  a_frame_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_vld_q && m_axis_tready && !frame_last |=>
      hold_vld_q && cnt_q == $past(cnt_q) + CNT_W'(1))
    else $error("frame sequence skipped or dropped");

  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_vld_q && !frame_last |-> !s_axis_tready)
    else $error("input taken while frames remain");

endmodule
`default_nettype wire

// File: rtl/fdss_dabble_stage.sv
`default_nettype none
module fdss_dabble_stage
  import fdss_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       en_i,
  input  wire logic       vld_i,
  input  wire fdss_item_t item_i,
  output logic            vld_o,
  output fdss_item_t      item_o
);

  logic       vld_q;
  fdss_item_t item_d, item_q;

  always_comb begin
    logic [VALUE_W-1:0] bin;
    logic [BCD_W-1:0]   bcd;
    bin = item_i.bin;
    bcd = item_i.bcd;
    for (int s = 0; s < BITS_PER_STAGE; s++) begin
      for (int d = 0; d < BCD_DIGITS; d++) begin
        if (bcd[d*4 +: 4] >= 4'd5) begin
          bcd[d*4 +: 4] = bcd[d*4 +: 4] + 4'd3;
        end
      end
      bcd = {bcd[BCD_W-2:0], bin[VALUE_W-1]};
      bin = {bin[VALUE_W-2:0], 1'b0};
    end
    item_d.bin = bin;
    item_d.bcd = bcd;
    item_d.dp  = item_i.dp;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule
`default_nettype wire

// File: dv/four_digit_seven_segment_frames_test.sv
module four_digit_seven_segment_frames_test;
  import fdss_pkg::*;

  localparam int RANDOM_ITEMS = 320;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 20;

  localparam logic [0:9][SEG_W-1:0] DIGIT_GLYPHS = {
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
  };

  typedef struct packed {
    logic [SEG_W-1:0] segments;
    logic [SEG_W-1:0] digit_select;
    logic             last;
    logic             rejected;
  } frame_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [DP_W-1:0]    frac_digits;
    logic [2:0]         typed_cnt;
    frame_t [0:4]       typed;
  } stim_row_t;

  localparam frame_t BLANK_FRAME  = {BLANK, BLANK, 1'b0, 1'b0};
  localparam frame_t REJECT_FRAME = {BLANK, BLANK, 1'b1, 1'b1};

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  m_axis_tuser;

  frame_t    frames_due [$];
  stim_row_t directed_rows [$];
  int        errors        = 0;
  int        src_idle_pct  = 0;
  int        sink_idle_pct = 0;
  int        sink_phase    = 0;
  int        sink_stall    = 0;

  four_digit_seven_segment_frames DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // value[31:0], frac_digits[34:32]
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // segments[7:0], digit_select[15:8]
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)    // rejected
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 25;
      default: return 60;
    endcase
  endfunction

  function automatic int pick_gap(input int idle_pct);
    if ($urandom_range(0, 99) >= idle_pct) return 0;
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void queue_digit_frames(input logic [VALUE_W-1:0] value,
                                             input logic [DP_W-1:0] frac_digits);
    logic [VALUE_W-1:0] shown;
    frame_t             f;
    if (frac_digits > FRAC_UNITS) begin
      frames_due.push_back(REJECT_FRAME);
      return;
    end
    frames_due.push_back(BLANK_FRAME);
    shown = value;
    for (int i = frac_digits; i < FRAC_UNITS; i++) shown = shown / 10;
    for (int i = 0; i < DIGITS; i++) begin
      f.segments     = DIGIT_GLYPHS[shown % 10];
      if (i == frac_digits) f.segments = f.segments & DP_MASK;
      f.digit_select = SEG_W'(1 << (i % SEG_W));
      f.last         = (i == DIGITS - 1);
      f.rejected     = 1'b0;
      frames_due.push_back(f);
      shown = shown / 10;
    end
  endfunction

  task automatic add_row(input logic [VALUE_W-1:0] value, input logic [DP_W-1:0] frac_digits,
                         input logic [2:0] typed_cnt, input frame_t [0:4] typed);
    stim_row_t r;
    r.value       = value;
    r.frac_digits = frac_digits;
    r.typed_cnt   = typed_cnt;
    r.typed       = typed;
    directed_rows.push_back(r);
  endtask

  task automatic send_item(input logic [VALUE_W-1:0] value, input logic [DP_W-1:0] frac_digits,
                           input logic [2:0] typed_cnt, input frame_t [0:4] typed);
    int gap;
    gap = pick_gap(src_idle_pct);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= {{(IN_DATA_W - VALUE_W - DP_W){1'b0}}, frac_digits, value};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    if (typed_cnt == 0) begin
      queue_digit_frames(value, frac_digits);
    end else begin
      for (int i = 0; i < typed_cnt; i++) frames_due.push_back(typed[i]);
    end
  endtask

  always @(posedge clk_i) begin
    if (sink_phase == 0) sink_idle_pct = pick_idle_pct();
    sink_phase = (sink_phase + 1) % 128;
    if (sink_stall == 0) sink_stall = pick_gap(sink_idle_pct);
    if (sink_stall > 0) begin
      m_axis_tready <= 1'b0;
      sink_stall--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    frame_t exp_f;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (frames_due.size() == 0) begin
        $error("unexpected frame: segments=%h digit_select=%h last=%b rejected=%b",
               m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tlast, m_axis_tuser);
        errors++;
      end else begin
        exp_f = frames_due.pop_front();
        if (m_axis_tdata[7:0] !== exp_f.segments) begin
          $error("segments: expected %h, actual %h", exp_f.segments, m_axis_tdata[7:0]);
          errors++;
        end
        if (m_axis_tdata[15:8] !== exp_f.digit_select) begin
          $error("digit_select: expected %h, actual %h", exp_f.digit_select,
                 m_axis_tdata[15:8]);
          errors++;
        end
        if (m_axis_tlast !== exp_f.last) begin
          $error("last: expected %b, actual %b", exp_f.last, m_axis_tlast);
          errors++;
        end
        if (m_axis_tuser !== exp_f.rejected) begin
          $error("rejected: expected %b, actual %b", exp_f.rejected, m_axis_tuser);
          errors++;
        end
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic [VALUE_W-1:0] value;
    logic [DP_W-1:0]    frac_digits;

    add_row(32'd0, 3'd0, 3'd5, {BLANK_FRAME, {8'h40, 8'h01, 2'b00}, {8'hC0, 8'h02, 2'b00},
                                {8'hC0, 8'h04, 2'b00}, {8'hC0, 8'h08, 2'b10}});
    add_row(32'd0, 3'd4, 3'd5, {BLANK_FRAME, {8'hC0, 8'h01, 2'b00}, {8'hC0, 8'h02, 2'b00},
                                {8'hC0, 8'h04, 2'b00}, {8'hC0, 8'h08, 2'b10}});
    add_row(32'hFFFF_FFFF, 3'd4, 3'd5, {BLANK_FRAME, {8'h92, 8'h01, 2'b00},
                                        {8'h90, 8'h02, 2'b00}, {8'hA4, 8'h04, 2'b00},
                                        {8'hF8, 8'h08, 2'b10}});
    add_row(32'hFFFF_FFFF, 3'd7, 3'd1, {REJECT_FRAME, 72'd0});
    add_row(32'd0, 3'd5, 3'd1, {REJECT_FRAME, 72'd0});
    add_row(32'd12345, 3'd6, 3'd1, {REJECT_FRAME, 72'd0});
    for (int f = 0; f <= FRAC_UNITS; f++) begin
      add_row(32'd9999, DP_W'(f), 3'd0, '0);
      add_row(32'd12345678, DP_W'(f), 3'd0, '0);
    end
    add_row(32'd1, 3'd4, 3'd0, '0);
    add_row(32'd10, 3'd3, 3'd0, '0);
    add_row(32'hFFFF_FFFF, 3'd0, 3'd0, '0);
    add_row(32'hFFFF_FFFF, 3'd2, 3'd0, '0);
    add_row(32'hAAAA_AAAA, 3'd1, 3'd0, '0);
    add_row(32'h5555_5555, 3'd3, 3'd0, '0);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_item(directed_rows[i].value, directed_rows[i].frac_digits,
                directed_rows[i].typed_cnt, directed_rows[i].typed);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 32 == 0) src_idle_pct = pick_idle_pct();
      case ($urandom_range(0, 3))
        0:       value = $urandom();
        1:       value = $urandom_range(0, 99999);
        2:       value = $urandom_range(0, 999);
        default: value = 32'hFFFF_FFFF - $urandom_range(0, 255);
      endcase
      if ($urandom_range(0, 99) < 85)
        frac_digits = DP_W'($urandom_range(0, FRAC_UNITS));
      else
        frac_digits = DP_W'($urandom_range(FRAC_UNITS + 1, 7));
      send_item(value, frac_digits, 3'd0, '0);
    end
    s_axis_tvalid <= 1'b0;

    while (frames_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// File: files.f
rtl/fdss_pkg.sv
rtl/fdss_dabble_stage.sv
rtl/four_digit_seven_segment_frames.sv
dv/four_digit_seven_segment_frames_test.sv
